// ----- rtl/cpd_pkg.sv -----
// Shared types and constants for the checksum packet deframer.
package cpd_pkg;

  localparam int WORD_W      = 16;
  localparam int HALF_W      = 32;
  localparam int ID_W        = 11;
  localparam int WIN_DEPTH   = 5;
  localparam int FILL_W      = 3;
  localparam int RTR_BIT     = 15;
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_SLIP  = 1'b1;

  // One classified event handed from the front end to the back end.
  typedef struct packed {
    logic                kind;
    logic [WORD_W-1:0]   head;
    logic [HALF_W-1:0]   data;
    logic [HALF_W-1:0]   stamp;
  } cpd_entry_t;

endpackage

// ----- rtl/cpd_front.sv -----
// Front end: word window, checksum test and event classification.
module cpd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cpd_pkg::WORD_W-1:0]  link_word,
  input  logic                        q_full,
  output logic                        q_push,
  output cpd_pkg::cpd_entry_t         q_entry
);
  import cpd_pkg::*;

  logic [WORD_W-1:0] window [WIN_DEPTH];
  logic [FILL_W-1:0] fill_count;
  logic              accept;
  logic [WORD_W-1:0] sum;
  logic              full_win;
  logic              head_nz;
  logic              match;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign full_win = (fill_count == FILL_W'(WIN_DEPTH));
  assign head_nz  = (window[0] != '0);
  assign sum      = window[0] + WORD_W'(1) + window[1] + window[2] + window[3] + window[4];
  assign match    = head_nz && (sum == link_word);

  // A result is raised only for a full window with a nonzero head.
  assign q_push = accept && full_win && head_nz;

  always_comb begin
    q_entry.kind  = match ? KIND_MATCH : KIND_SLIP;
    q_entry.head  = window[0];
    q_entry.data  = {window[2], window[1]};
    q_entry.stamp = {window[4], window[3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      if (!full_win) begin
        if (fill_count != '0 || link_word != '0) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end else if (match) begin
        fill_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!full_win) begin
        if (fill_count != '0 || link_word != '0) begin
          window[fill_count] <= link_word;
        end
      end else if (!match) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          window[i] <= window[i+1];
        end
        window[WIN_DEPTH-1] <= link_word;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WIN_DEPTH))
    else $error("window fill count out of range");

  a_zero_discard: assert property (@(posedge clk) disable iff (rst)
    accept && fill_count == '0 && link_word == '0 |=> fill_count == '0)
    else $error("leading zero word was not discarded");

  a_match_empties: assert property (@(posedge clk) disable iff (rst)
    q_push && q_entry.kind == KIND_MATCH |=> fill_count == '0)
    else $error("window not emptied after a valid packet");

endmodule

// ----- rtl/cpd_queue.sv -----
// Short event queue between the front end and the back end.
module cpd_queue #(
  parameter int DEPTH = cpd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  cpd_pkg::cpd_entry_t  wr_entry,
  input  logic                 pop,
  output logic                 rd_valid,
  output cpd_pkg::cpd_entry_t  rd_entry
);
  import cpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpd_entry_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  assign full = (count == CNT_W'(DEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    do_pop && !push && count == CNT_W'(1) |=> !rd_valid)
    else $error("queue not empty after last entry popped");

endmodule

// ----- rtl/cpd_back.sv -----
// Back end: packet counter and registered result stage.
module cpd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  cpd_pkg::cpd_entry_t          q_entry,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic [cpd_pkg::ID_W-1:0]     node_id,
  output logic                         remote_request,
  output logic [cpd_pkg::HALF_W-1:0]   data_word,
  output logic [cpd_pkg::HALF_W-1:0]   stamp,
  output logic [cpd_pkg::HALF_W-1:0]   packets_accepted
);
  import cpd_pkg::*;

  logic [HALF_W-1:0] packet_total;
  logic [HALF_W-1:0] total_next;
  logic              is_match;

  assign q_pop      = q_valid && (!out_valid || !out_stall);
  assign is_match   = (q_entry.kind == KIND_MATCH);
  assign total_next = is_match ? packet_total + HALF_W'(1) : packet_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      packet_total <= '0;
    end else begin
      if (q_pop) begin
        out_valid    <= 1'b1;
        packet_total <= total_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Slip reports carry only the kind and the running count.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind             <= q_entry.kind;
      node_id          <= is_match ? q_entry.head[ID_W-1:0] : '0;
      remote_request   <= is_match ? q_entry.head[RTR_BIT] : 1'b0;
      data_word        <= is_match ? q_entry.data : '0;
      stamp            <= is_match ? q_entry.stamp : '0;
      packets_accepted <= total_next;
    end
  end

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_valid)
    else $error("popped event did not reach the output stage");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packets_accepted == packet_total)
    else $error("reported count differs from packet total");

  a_slip_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SLIP |-> data_word == '0 && stamp == '0 && node_id == '0)
    else $error("slip report carries payload");

endmodule

// ----- rtl/checksum_packet_deframer_unit.sv -----
// Top level of the checksum packet deframer.
//
// The input channel (in_valid, in_stall, link_word) moves one 16-bit link
// word per transfer. The block keeps a five-word window and tests each new
// word as the checksum of the held packet. Leading zero words are dropped.
// On a match it reports the packet (kind 0) with node id, remote bit, data
// and time stamp, counts it and empties the window. On a mismatch with a
// nonzero head word it reports a slip (kind 1) and slides by one word.
// Results leave on the output channel (out_valid, out_stall and the fields).
// A result passes first through the front end, which classifies the word and
// writes an event into a small queue, and then through the back end, which
// counts packets and loads the output register. One word is taken every
// cycle while in_stall is low; the checksum is a single six-term 16-bit add
// and compare. When the receiver stalls, the output register holds and the
// queue fills; in_stall rises only once the queue is full. Synchronous reset
// empties the window, the queue and the output stage and clears the packet
// count.
module checksum_packet_deframer_unit #(
  parameter int QUEUE_DEPTH = cpd_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cpd_pkg::WORD_W-1:0]   link_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic [cpd_pkg::ID_W-1:0]     node_id,
  output logic                         remote_request,
  output logic [cpd_pkg::HALF_W-1:0]   data_word,
  output logic [cpd_pkg::HALF_W-1:0]   stamp,
  output logic [cpd_pkg::HALF_W-1:0]   packets_accepted
);
  import cpd_pkg::*;

  cpd_entry_t q_wr_entry;
  cpd_entry_t q_rd_entry;
  logic       q_rd_valid;
  logic       q_pop;
  logic       q_push;
  logic       q_full;

  // The front end only pushes on a transfer, which the full flag blocks.
  cpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .link_word (link_word),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  cpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .full     (q_full),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_valid (q_rd_valid),
    .rd_entry (q_rd_entry)
  );

  cpd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_rd_valid),
    .q_entry          (q_rd_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .node_id          (node_id),
    .remote_request   (remote_request),
    .data_word        (data_word),
    .stamp            (stamp),
    .packets_accepted (packets_accepted)
  );

endmodule
